[sv/four_level_page_walker_top_defines.svh]
// assertion macros for the four-level page walker checker
// no dependencies; included by the checker file only
`ifndef FOUR_LEVEL_PAGE_WALKER_TOP_DEFINES_SVH
`define FOUR_LEVEL_PAGE_WALKER_TOP_DEFINES_SVH

// same-cycle implication under reset
`define FLPW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("page walker assertion failed");

// next-cycle implication under reset
`define FLPW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("page walker assertion failed");

`endif

[sv/flpw_pkg.sv]
// shared constants, types and helpers of the four-level page walker
// no dependencies
`timescale 1ns / 1ps

package flpw_pkg;

    localparam int STORE_WORDS_DEF = 4096;
    localparam int WORD_W          = 64;
    localparam int WIDX_W          = 12;
    localparam int VA_W            = 48;
    localparam int PA_W            = 47;
    localparam int TIDX_W          = 9;
    localparam int FULL_ADDR_W     = 44;
    localparam int PRESENT_BIT     = 0;
    localparam int HUGE_BIT        = 7;

    localparam logic [1:0] HUGE_LEVEL = 2'd2;
    localparam logic [1:0] LAST_LEVEL = 2'd3;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_XLATE = 1'b1;

    typedef struct packed {
        logic clr_wr;
        logic wr;
        logic start;
        logic step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic       clr_last;
        logic       present;
        logic       huge;
        logic [1:0] level;
    } t_dp_stat;

    function automatic logic [TIDX_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                    input logic [1:0] level);
        logic [TIDX_W-1:0] idx;
        case (level)
            2'd0: idx = va[47:39];
            2'd1: idx = va[38:30];
            2'd2: idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

[sv/flpw_ctrl.sv]
// walk sequencer: clearing pass, item intake, level stepping, result handoff
// depends on flpw_pkg
`timescale 1ns / 1ps

module flpw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    input  logic              i_s_kind,
    output logic              o_s_ready,
    input  logic              i_m_ready,
    output logic              o_m_valid,
    input  flpw_pkg::t_dp_stat i_stat,
    output flpw_pkg::t_dp_cmd  o_cmd
);
    import flpw_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK
    } t_state;

    t_state  r_state, n_state;
    logic    r_ready, n_ready;
    logic    r_out_valid, n_out_valid;
    t_dp_cmd cmd;
    logic    out_free;
    logic    walk_end;

    assign out_free = !r_out_valid || i_m_ready;
    assign walk_end = (i_stat.level == HUGE_LEVEL && i_stat.huge) || !i_stat.present
                      || i_stat.level == LAST_LEVEL;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_valid && r_ready) begin
                    if (i_s_kind == KIND_WRITE) begin
                        cmd.wr = 1'b1;
                    end else begin
                        cmd.start = 1'b1;
                        n_state   = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (walk_end) begin
                    if (out_free) begin
                        cmd.finish = 1'b1;
                        n_state    = ST_IDLE;
                    end
                end else begin
                    cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
        n_ready     = (n_state == ST_IDLE);
        n_out_valid = cmd.finish ? 1'b1 : (i_m_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_ready     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ready     <= n_ready;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_ready = r_ready;
    assign o_m_valid = r_out_valid;
    assign o_cmd     = cmd;

endmodule

[sv/flpw_datapath.sv]
// table store, address forming, entry register and result register
// depends on flpw_pkg
`timescale 1ns / 1ps

module flpw_datapath #(
    parameter int STORE_WORDS = flpw_pkg::STORE_WORDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  flpw_pkg::t_dp_cmd             i_cmd,
    output flpw_pkg::t_dp_stat            o_stat,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_wdata,
    input  logic [flpw_pkg::WIDX_W-1:0]   i_word_index,
    input  logic [flpw_pkg::WORD_W-1:0]   i_word_value,
    input  logic [flpw_pkg::VA_W-1:0]     i_virtual_address,
    output logic [flpw_pkg::PA_W-1:0]     o_physical_address,
    output logic                          o_fault,
    output logic                          o_huge_page
);
    import flpw_pkg::*;

    localparam int AW = $clog2(STORE_WORDS);

    logic [WORD_W-1:0]      mem [STORE_WORDS];
    logic [WORD_W-1:0]      r_rdata;
    logic [AW-1:0]          r_rd_addr, rd_addr;
    logic [AW-1:0]          r_clr_addr;
    logic [2:0]             r_root;
    logic [VA_W-1:0]        r_va;
    logic [1:0]             r_level;
    logic [PA_W-1:0]        r_pa;
    logic                   r_fault;
    logic                   r_huge;
    logic [FULL_ADDR_W-1:0] first_full, next_full;
    logic [15:0]            widx_ext;
    logic [1:0]             next_level;
    logic                   is_huge_end;

    assign next_level  = r_level + 2'd1;
    assign first_full  = {35'(r_root), va_index(i_virtual_address, 2'd0)};
    assign next_full   = {r_rdata[46:12], va_index(r_va, next_level)};
    assign widx_ext    = 16'(i_word_index);
    assign is_huge_end = (r_level == HUGE_LEVEL) && r_rdata[HUGE_BIT];

    always_comb begin
        if (i_cmd.start) begin
            rd_addr = first_full[AW-1:0];
        end else if (i_cmd.step) begin
            rd_addr = next_full[AW-1:0];
        end else begin
            rd_addr = r_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            mem[r_clr_addr] <= '0;
        end else if (i_cmd.wr) begin
            mem[widx_ext[AW-1:0]] <= i_word_value;
        end
        r_rdata   <= mem[rd_addr];
        r_rd_addr <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_root     <= '0;
            r_level    <= '0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_we) begin
                r_root <= i_cfg_wdata;
            end
            if (i_cmd.start) begin
                r_level <= '0;
            end else if (i_cmd.step) begin
                r_level <= next_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_va <= i_virtual_address;
        end
        if (i_cmd.finish) begin
            if (is_huge_end) begin
                r_pa    <= {r_rdata[46:21], r_va[20:0]};
                r_fault <= 1'b0;
                r_huge  <= 1'b1;
            end else if (!r_rdata[PRESENT_BIT]) begin
                r_pa    <= '0;
                r_fault <= 1'b1;
                r_huge  <= 1'b0;
            end else begin
                r_pa    <= {r_rdata[46:12], r_va[11:0]};
                r_fault <= 1'b0;
                r_huge  <= 1'b0;
            end
        end
    end

    assign o_stat.clr_last = (r_clr_addr == AW'(STORE_WORDS - 1));
    assign o_stat.present  = r_rdata[PRESENT_BIT];
    assign o_stat.huge     = r_rdata[HUGE_BIT];
    assign o_stat.level    = r_level;

    assign o_physical_address = r_pa;
    assign o_fault            = r_fault;
    assign o_huge_page        = r_huge;

endmodule

[sv/four_level_page_walker_top.sv]
// Four-level page table walker over an internal store of 64-bit table words.
// Input channel s_axis: tuser is the item kind (0 writes one store word,
// 1 translates a 48-bit virtual address). Output channel m_axis carries one
// item per translate: the 47-bit physical address in tdata, fault and
// huge-page flags in tuser. Writes give no output item.
// Configuration: i_cfg_we writes i_cfg_wdata as the root table slot; write
// only while no walk is in flight.
// A write item is stored at the edge that accepts it; back-to-back writes are accepted each cycle.
// A translate reads one store word per level from a single read port, one
// level per cycle; the result is registered when the walk ends, and the next
// item can be taken in the same cycle that the result appears.
// STORE_WORDS must be a power of two.
// Reset: the root slot goes to zero and the store is cleared one word per
// cycle, with s_axis_tready low throughout.
// The result sits in an output register; new items are accepted while it
// waits, and a finished walk holds until the register is free.
`timescale 1ns / 1ps

module four_level_page_walker_top #(
    parameter int STORE_WORDS = flpw_pkg::STORE_WORDS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // word_index, word_value, virtual_address, zero pad
    input  logic         s_axis_tuser,   // kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [47:0]  m_axis_tdata,   // physical_address, zero pad
    output logic [1:0]   m_axis_tuser    // fault, huge_page
);
    import flpw_pkg::*;

    t_dp_cmd          cmd;
    t_dp_stat         stat;
    logic [PA_W-1:0]  pa;
    logic             fault;
    logic             huge;

    flpw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_s_kind  (s_axis_tuser),
        .o_s_ready (s_axis_tready),
        .i_m_ready (m_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    flpw_datapath #(
        .STORE_WORDS (STORE_WORDS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_word_index       (s_axis_tdata[11:0]),
        .i_word_value       (s_axis_tdata[75:12]),
        .i_virtual_address  (s_axis_tdata[123:76]),
        .o_physical_address (pa),
        .o_fault            (fault),
        .o_huge_page        (huge)
    );

    assign m_axis_tdata = {1'b0, pa};
    assign m_axis_tuser = {huge, fault};

endmodule

[sv/flpw_checker.sv]
// port-level checks for the four-level page walker, bound to the top level
// depends on four_level_page_walker_top_defines.svh and flpw_pkg
`timescale 1ns / 1ps
`include "four_level_page_walker_top_defines.svh"

module flpw_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [47:0]  m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);
    import flpw_pkg::*;

    logic out_stall;
    logic xlate_acc;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign xlate_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_XLATE);

    `FLPW_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `FLPW_ASSERT_NOW(a_fault_clean, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0],
        m_axis_tdata == 48'd0 && !m_axis_tuser[1])
    `FLPW_ASSERT_NOW(a_clear_blocks, i_clk, i_rst_n, !$past(i_rst_n), !s_axis_tready)
    `FLPW_ASSERT_NEXT(a_walk_busy, i_clk, i_rst_n, xlate_acc, !s_axis_tready)

endmodule

bind four_level_page_walker_top flpw_checker u_flpw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
